// File: src/checked_int63_alu_core_assert.svh
// Assertion macros used by the port checker (cia_checker).
`ifndef CHECKED_INT63_ALU_CORE_ASSERT_SVH
`define CHECKED_INT63_ALU_CORE_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define CIA_ASSERT_IMPL(lbl, clk, rst, cond, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");
// Implication checked in the cycle after the condition.
`define CIA_ASSERT_NEXT(lbl, clk, rst, cond, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");
`endif

// File: src/cia_pkg.sv
package cia_pkg;
   localparam int unsigned DataWidth = 63;
   localparam int unsigned StepCount = 63;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_MOD = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_OVF  = 2'd1,
      ST_DIV0 = 2'd2
   } status_type;

   // Per-item record that moves down the cell row.
   typedef struct packed {
      logic                  valid;
      logic [2:0]            opcode;
      logic                  neg_res;
      logic                  neg_a;
      logic                  done;
      logic [1:0]            status;
      logic [DataWidth-1:0]  early;
      logic [DataWidth-1:0]  ma;
      logic [DataWidth-1:0]  mb;
      logic [DataWidth:0]    acc;
      logic [DataWidth-1:0]  quo;
      logic                  ovf;
   } slot_type;
endpackage

// File: src/cia_cell.sv
// One step of the row: a shift-add multiply step for multiply requests, else one
// restoring divide step, for the operand bit picked by the cell position.
module cia_cell #(
   parameter int unsigned Index = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  cia_pkg::slot_type slot_in,
   output cia_pkg::slot_type slot_out
);
   import cia_pkg::*;

   localparam int unsigned Bit = DataWidth - 1 - Index;

   slot_type slot_in_c;
   slot_type slot_ff;
   logic [DataWidth:0]   sum_w;
   logic [DataWidth:0]   rem_sh;
   logic [DataWidth+1:0] rem_diff;

   assign slot_out = slot_ff;

   // Multiply: MSB-first, acc = 2*acc + (bit ? ma : 0), overflow sticky.
   // Divide: acc holds remainder, quotient bits fill quo.
   always_comb begin
      slot_in_c = slot_in;
      sum_w    = '0;
      rem_sh   = '0;
      rem_diff = '0;
      if (slot_in.opcode == OP_MUL) begin
         if (slot_in.acc[DataWidth] || slot_in.acc[DataWidth-1]) begin
            slot_in_c.ovf = 1'b1;
         end
         sum_w = {slot_in.acc[DataWidth-1:0], 1'b0}
               + (slot_in.mb[Bit] ? {1'b0, slot_in.ma} : '0);
         slot_in_c.acc = sum_w;
         if (sum_w[DataWidth]) begin
            slot_in_c.ovf = 1'b1;
         end
      end else begin
         rem_sh   = {slot_in.acc[DataWidth-1:0], slot_in.ma[Bit]};
         rem_diff = {1'b0, rem_sh} - {2'b00, slot_in.mb};
         if (!rem_diff[DataWidth+1]) begin
            slot_in_c.acc      = rem_diff[DataWidth:0];
            slot_in_c.quo[Bit] = 1'b1;
         end else begin
            slot_in_c.acc      = rem_sh;
            slot_in_c.quo[Bit] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else if (advance) begin
         slot_ff.valid <= slot_in.valid;
      end
      if (advance) begin
         slot_ff.opcode  <= slot_in_c.opcode;
         slot_ff.neg_res <= slot_in_c.neg_res;
         slot_ff.neg_a   <= slot_in_c.neg_a;
         slot_ff.done    <= slot_in_c.done;
         slot_ff.status  <= slot_in_c.status;
         slot_ff.early   <= slot_in_c.early;
         slot_ff.ma      <= slot_in_c.ma;
         slot_ff.mb      <= slot_in_c.mb;
         slot_ff.acc     <= slot_in_c.acc;
         slot_ff.quo     <= slot_in_c.quo;
         slot_ff.ovf     <= slot_in_c.ovf;
      end
   end
endmodule

// File: src/cia_front.sv
// Entry stage: add/sub done here, magnitudes and signs prepared for the row.
module cia_front (
   input  logic [2:0]                    opcode,
   input  logic [cia_pkg::DataWidth-1:0] operand_a,
   input  logic [cia_pkg::DataWidth-1:0] operand_b,
   input  logic                          valid,
   output cia_pkg::slot_type             slot
);
   import cia_pkg::*;

   logic [DataWidth:0] a_x;
   logic [DataWidth:0] b_x;
   logic [DataWidth:0] sum_x;
   logic               neg_a;
   logic               neg_b;

   assign neg_a = operand_a[DataWidth-1];
   assign neg_b = operand_b[DataWidth-1];
   assign a_x   = {neg_a, operand_a};
   assign b_x   = {neg_b, operand_b};

   always_comb begin
      sum_x = '0;
      slot         = '0;
      slot.valid   = valid;
      slot.opcode  = opcode;
      slot.neg_a   = neg_a;
      slot.neg_res = neg_a ^ neg_b;
      // magnitudes: 2^62 fits in 63 unsigned bits
      slot.ma      = neg_a ? (~operand_a + 1'b1) : operand_a;
      slot.mb      = neg_b ? (~operand_b + 1'b1) : operand_b;
      slot.status  = ST_OK;
      unique case (opcode)
         OP_ADD, OP_SUB: begin
            sum_x = (opcode == OP_ADD) ? (a_x + b_x) : (a_x - b_x);
            slot.done = 1'b1;
            if (sum_x[DataWidth] != sum_x[DataWidth-1]) begin
               slot.status = ST_OVF;
            end else begin
               slot.early = sum_x[DataWidth-1:0];
            end
         end
         OP_MUL: begin
         end
         OP_DIV, OP_MOD: begin
            if (operand_b == '0) begin
               slot.done   = 1'b1;
               slot.status = ST_DIV0;
            end
         end
         default: begin
            slot.done = 1'b1;
         end
      endcase
   end
endmodule

// File: src/checked_int63_alu_core.sv
// Checked 63-bit signed ALU: add, subtract, multiply, divide, modulo.
// Request channel req_*: tdata = {operand_b, operand_a, opcode}, one request
// accepted per cycle when req_tready is high.
// Response channel rsp_*: tdata = {status, result_value}, one response per
// request, in request order.
// Each request passes through the 63-cell row of multiply and divide steps,
// one operand bit per cell, then the output register. Throughput: one request
// per cycle while req_tready is high.
// Add, subtract and zero-divisor requests ride the same row, result carried unchanged.
// Overflow or divide by zero give status 1 or 2 with result_value zero;
// unused opcodes give zero with status ok.
// Reset (synchronous, active high) empties the row and the output register.
// When rsp_tready is low and the output register is full the whole row
// holds; req_tready then drops, so nothing is lost.
module checked_int63_alu_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [135:0] req_tdata,  // opcode[2:0], operand_a[65:3], operand_b[128:66]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata   // result_value[62:0], status[64:63]
);
   import cia_pkg::*;

   logic     advance;
   slot_type row [0:StepCount];
   slot_type tail;
   logic [DataWidth-1:0] res_in;
   logic [1:0]           st_in;
   logic [DataWidth-1:0] res_ff;
   logic [1:0]           st_ff;
   logic                 out_valid_ff;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   cia_front u_front (
      .opcode    (req_tdata[2:0]),
      .operand_a (req_tdata[65:3]),
      .operand_b (req_tdata[128:66]),
      .valid     (req_tvalid),
      .slot      (row[0])
   );

   // row of step cells
   for (genvar i = 0; i < StepCount; i++) begin : g_cell
      cia_cell #(.Index(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .slot_in  (row[i]),
         .slot_out (row[i+1])
      );
   end

   assign tail = row[StepCount];

   // finish: apply signs and range checks
   always_comb begin
      res_in = '0;
      st_in  = tail.status;
      if (tail.done) begin
         res_in = (tail.status == ST_OK) ? tail.early : '0;
      end else if (tail.opcode == OP_MUL) begin
         if (tail.ovf || tail.acc[DataWidth]
             || (tail.acc[DataWidth-1:0] > {1'b0, {(DataWidth-1){1'b1}}}
                 + {{(DataWidth-1){1'b0}}, tail.neg_res})) begin
            st_in = ST_OVF;
         end else begin
            res_in = tail.neg_res ? (~tail.acc[DataWidth-1:0] + 1'b1)
                                  : tail.acc[DataWidth-1:0];
         end
      end else if (tail.opcode == OP_DIV) begin
         if (!tail.neg_res && tail.quo[DataWidth-1]) begin
            st_in = ST_OVF;
         end else begin
            res_in = tail.neg_res ? (~tail.quo + 1'b1) : tail.quo;
         end
      end else begin
         res_in = tail.neg_a ? (~tail.acc[DataWidth-1:0] + 1'b1)
                             : tail.acc[DataWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= tail.valid;
      end
      if (advance) begin
         res_ff <= res_in;
         st_ff  <= st_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, st_ff, res_ff};
endmodule

// File: src/cia_checker.sv
// Port-level checks on the ALU core.
module cia_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [71:0]  rsp_tdata
);
`include "checked_int63_alu_core_assert.svh"
   import cia_pkg::*;

   `CIA_ASSERT_IMPL(a_status_code, clock, reset, rsp_tvalid, rsp_tdata[64:63] != 2'd3)
   `CIA_ASSERT_IMPL(a_err_zero, clock, reset, rsp_tvalid && rsp_tdata[64:63] != ST_OK, rsp_tdata[62:0] == '0)
   `CIA_ASSERT_IMPL(a_ready_stall, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)
   `CIA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
endmodule

bind checked_int63_alu_core cia_checker u_cia_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: tb/tb_checked_int63_alu_core_checker.sv
module tb_checked_int63_alu_core_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [135:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [71:0]  rsp_tdata,
   output int           fail_count,
   output int           pending_count
);
   import cia_pkg::*;

   typedef struct packed {
      logic [62:0] value;
      logic [1:0]  status;
   } alu_result_type;

   localparam logic [63:0] MAX_POS = 64'h3FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] MIN_MAG = 64'h4000_0000_0000_0000;

   alu_result_type expected_results[$];

   function automatic logic [62:0] signed_from_mag(logic neg, logic [63:0] m);
      logic [63:0] t;
      t = neg ? (64'd0 - m) : m;
      return t[62:0];
   endfunction

   // Exact checked arithmetic on sign-extended operands
   function automatic alu_result_type compute_alu(logic [2:0] op, logic [62:0] a63,
                                                  logic [62:0] b63);
      logic [63:0]    a, b, ma, mb, s, lim, q;
      logic [127:0]   prod;
      logic           neg;
      alu_result_type r;
      a = {a63[62], a63};
      b = {b63[62], b63};
      ma = a[63] ? (64'd0 - a) : a;
      mb = b[63] ? (64'd0 - b) : b;
      neg = a[63] ^ b[63];
      r.value = '0;
      r.status = ST_OK;
      case (op)
         OP_ADD, OP_SUB: begin
            s = (op == OP_ADD) ? a + b : a - b;
            if (s[63] == s[62]) r.value = s[62:0];
            else r.status = ST_OVF;
         end
         OP_MUL: begin
            lim = neg ? MIN_MAG : MAX_POS;
            prod = ma * mb;
            if (prod > {64'd0, lim}) r.status = ST_OVF;
            else r.value = signed_from_mag(neg, prod[63:0]);
         end
         OP_DIV, OP_MOD: begin
            if (b == 64'd0) r.status = ST_DIV0;
            else if (op == OP_DIV) begin
               q = ma / mb;
               if (!neg && q > MAX_POS) r.status = ST_OVF;
               else r.value = signed_from_mag(neg, q);
            end else begin
               r.value = signed_from_mag(a[63], ma % mb);
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // Predict on each accepted request, compare on each accepted response
   always @(posedge clock) begin
      alu_result_type want, got;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.value = rsp_tdata[62:0];
            got.status = rsp_tdata[64:63];
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected response value=%h status=%0d",
                        $time, got.value, got.status);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (want.status != got.status) begin
                  $display("%0t: status expected %0d actual %0d", $time,
                           want.status, got.status);
                  fail_count <= fail_count + 1;
               end else if (want.value != got.value) begin
                  $display("%0t: result_value expected %h actual %h", $time,
                           want.value, got.value);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(compute_alu(req_tdata[2:0], req_tdata[65:3],
                                                   req_tdata[128:66]));
      end
      pending_count = expected_results.size();
   end
endmodule

// File: tb/tb_checked_int63_alu_core.sv
module tb_checked_int63_alu_core;
   import cia_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;  // opcode, operand_a, operand_b
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [71:0]  rsp_tdata;       // result_value, status
   int           fail_count;
   int           pending_count;
   int           send_idle_pct;
   int           recv_idle_pct;

   localparam logic [62:0] MAX63 = 63'h3FFF_FFFF_FFFF_FFFF;
   localparam logic [62:0] MIN63 = 63'h4000_0000_0000_0000;
   localparam logic [62:0] NEG1  = '1;

   always #5 clock = ~clock;

   checked_int63_alu_core dut (.*);

   tb_checked_int63_alu_core_checker u_checker (.*);

   // Response side stall
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   // Operand with a random magnitude class so mul/div cover fits and overflows
   function automatic logic [62:0] rand_operand();
      logic [62:0] v;
      int          bits;
      v = 63'({$urandom, $urandom});
      case ($urandom_range(7))
         0: v = MAX63 - $urandom_range(2);
         1: v = MIN63 + $urandom_range(2);
         2: v = 63'($signed($urandom_range(6)) - 3);
         3, 4: begin
            bits = $urandom_range(62, 1);
            v = v & ((63'd1 << bits) - 1);
            if ($urandom_range(1)) v = -v;
         end
         default: ;
      endcase
      return v;
   endfunction

   task automatic send_request(logic [2:0] op, logic [62:0] a, logic [62:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, b, a, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_random(int count);
      logic [2:0] op;
      repeat (count) begin
         op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
                                       : 3'($urandom_range(4));
         send_request(op, rand_operand(), rand_operand());
      end
   endtask

   initial begin
      send_idle_pct = 21;
      recv_idle_pct = 80;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: extremes, every operation, special cases
      send_request(OP_ADD, MAX63, 63'd1);
      send_request(OP_ADD, MIN63, NEG1);
      send_request(OP_ADD, MAX63, MIN63);
      send_request(OP_SUB, MIN63, 63'd1);
      send_request(OP_SUB, 63'd0, MIN63);
      send_request(OP_SUB, NEG1, MAX63);
      send_request(OP_MUL, MIN63, 63'd1);
      send_request(OP_MUL, MIN63, NEG1);
      send_request(OP_MUL, 63'h2000_0000_0000_0000, NEG1 - 1);
      send_request(OP_MUL, 63'h2000_0000_0000_0000, 63'd2);
      send_request(OP_MUL, MAX63, MAX63);
      send_request(OP_MUL, 63'd0, MIN63);
      send_request(OP_DIV, MIN63, NEG1);
      send_request(OP_MOD, MIN63, NEG1);
      send_request(OP_DIV, MAX63, 63'd0);
      send_request(OP_MOD, MIN63, 63'd0);
      send_request(OP_DIV, 63'($signed(-7)), 63'd2);
      send_request(OP_MOD, 63'($signed(-7)), 63'd2);
      send_request(OP_MOD, 63'd7, 63'($signed(-2)));
      send_request(OP_DIV, MIN63, MAX63);
      send_request(3'd5, MAX63, MAX63);
      send_request(3'd6, MIN63, NEG1);
      send_request(3'd7, NEG1, NEG1);
      send_random(550);
      send_idle_pct = 80;
      recv_idle_pct = 21;
      send_random(560);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(570);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (fail_count == 0)
         $display("PASS checked_int63_alu_core");
      else
         $display("FAIL checked_int63_alu_core");
      $finish;
   end

   initial begin
      #3000000;
      $display("FAIL checked_int63_alu_core");
      $finish;
   end
endmodule
